// File: design/pcrs_pkg.sv
// Package for the point cloud radius smoothing block.
// Holds the sizes, register codes and status structs used by every design file except pcrs_ram.
// Depends on nothing.
package pcrs_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 3 * COORD_BITS;
    localparam int SUM_W      = COORD_BITS + IDX_W + 1;
    localparam int MAG_W      = SUM_W - 1;
    localparam int RAD_W      = 23;
    localparam int ITER_W     = 4;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [RAD_W-1:0]     RAD_RESET  = RAD_W'(2048);
    localparam logic [ITER_W-1:0]    ITER_RESET = ITER_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER   = 1'b1;

    typedef struct packed {
        logic                    busy;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0]        cnt;
    } t_acc;

    typedef struct packed {
        logic            done;
        logic [PT_W-1:0] pt;
    } t_div_out;

endpackage

// File: design/pcrs_if.sv
// Channel interfaces of the point cloud radius smoothing block.
// Depends on pcrs_pkg for the coordinate and register index widths.
interface pcrs_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     command;
    logic signed [pcrs_pkg::COORD_BITS-1:0]   in_x;
    logic signed [pcrs_pkg::COORD_BITS-1:0]   in_y;
    logic signed [pcrs_pkg::COORD_BITS-1:0]   in_z;
    logic                                     in_last;
    modport source(output valid, command, in_x, in_y, in_z, in_last, input ready);
    modport sink(input valid, command, in_x, in_y, in_z, in_last, output ready);
endinterface

interface pcrs_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pcrs_pkg::COORD_BITS-1:0]   out_x;
    logic signed [pcrs_pkg::COORD_BITS-1:0]   out_y;
    logic signed [pcrs_pkg::COORD_BITS-1:0]   out_z;
    logic                                     out_last;
    modport source(output valid, out_x, out_y, out_z, out_last, input ready);
    modport sink(input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

interface pcrs_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pcrs_pkg::CFG_IDX_W-1:0]       index;
    logic [pcrs_pkg::RAD_W-1:0]           data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: design/pcrs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pcrs_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/pcrs_div.sv
// Three-lane restoring divider giving the rounded mean of each axis.
// Depends on pcrs_pkg for widths and the result struct.
module pcrs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic signed [pcrs_pkg::SUM_W-1:0] i_sx,
    input  logic signed [pcrs_pkg::SUM_W-1:0] i_sy,
    input  logic signed [pcrs_pkg::SUM_W-1:0] i_sz,
    input  logic [pcrs_pkg::CNT_W-1:0]        i_den,
    output pcrs_pkg::t_div_out                o_res
);
    localparam int MW = pcrs_pkg::MAG_W;
    localparam int CW = pcrs_pkg::CNT_W;
    localparam int C  = pcrs_pkg::COORD_BITS;
    localparam int SW = $clog2(MW + 1);

    logic [MW-1:0] r_q   [3];
    logic [CW:0]   r_rem [3];
    logic [MW-1:0] n_q   [3];
    logic [CW:0]   n_rem [3];
    logic [2:0]    r_neg;
    logic [CW-1:0] r_den;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic          r_done;
    logic signed [pcrs_pkg::SUM_W-1:0] w_s [3];
    logic [pcrs_pkg::SUM_W-1:0]        w_abs [3];
    logic [C-1:0]  w_out [3];

    assign w_s[0] = i_sx;
    assign w_s[1] = i_sy;
    assign w_s[2] = i_sz;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [CW:0] sh;
            w_abs[a] = w_s[a][pcrs_pkg::SUM_W-1] ? -w_s[a] : w_s[a];
            sh = {r_rem[a][CW-1:0], r_q[a][MW-1]};
            if (sh >= {1'b0, r_den}) begin
                n_rem[a] = sh - {1'b0, r_den};
                n_q[a]   = {r_q[a][MW-2:0], 1'b1};
            end else begin
                n_rem[a] = sh;
                n_q[a]   = {r_q[a][MW-2:0], 1'b0};
            end
            w_out[a] = r_neg[a] ? C'(-r_q[a]) : C'(r_q[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_go && (r_step == SW'(MW - 1));
            if (i_go) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_den  <= i_den;
                for (int a = 0; a < 3; a++) begin
                    r_q[a]   <= w_abs[a][MW-1:0] + MW'(i_den >> 1);
                    r_rem[a] <= '0;
                    r_neg[a] <= w_s[a][pcrs_pkg::SUM_W-1];
                end
            end else if (r_busy) begin
                for (int a = 0; a < 3; a++) begin
                    r_q[a]   <= n_q[a];
                    r_rem[a] <= n_rem[a];
                end
                r_step <= r_step + 1'b1;
                if (r_step == SW'(MW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.pt   = {w_out[2], w_out[1], w_out[0]};
endmodule

// File: design/pcrs_nbr.sv
// Neighbour test and accumulation pipeline for one point of a smoothing pass.
// Depends on pcrs_pkg for widths and the accumulator struct.
module pcrs_nbr (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_valid,
    input  logic [pcrs_pkg::IDX_W-1:0]        i_tag,
    input  logic [pcrs_pkg::IDX_W-1:0]        i_self_idx,
    input  logic [pcrs_pkg::PT_W-1:0]         i_self,
    input  logic [pcrs_pkg::PT_W-1:0]         i_pt,
    input  logic [pcrs_pkg::RAD_W-1:0]        i_radius,
    input  logic [pcrs_pkg::SQ_W-1:0]         i_r2,
    output pcrs_pkg::t_acc                    o_acc
);
    localparam int C  = pcrs_pkg::COORD_BITS;
    localparam int RW = pcrs_pkg::RAD_W;
    localparam int SQ = pcrs_pkg::SQ_W;
    localparam int SM = pcrs_pkg::SUM_W;

    logic                r1_v, r1_ok, r2_v, r2_ok;
    logic [RW-1:0]       r1_m  [3];
    logic signed [C-1:0] r1_c  [3];
    logic [SQ-1:0]       r2_sq [3];
    logic signed [C-1:0] r2_c  [3];
    logic signed [SM-1:0] r_sum [3];
    logic [pcrs_pkg::CNT_W-1:0] r_cnt;
    logic [RW-1:0]       w_m [3];
    logic                w_ok;
    logic [SQ+1:0]       w_d2;

    always_comb begin
        w_ok = (i_tag != i_self_idx);
        for (int a = 0; a < 3; a++) begin
            logic signed [C:0] d;
            logic [C:0]        m;
            d = {i_pt[a*C + C - 1], i_pt[a*C +: C]}
              - {i_self[a*C + C - 1], i_self[a*C +: C]};
            m = d[C] ? -d : d;
            if (m > (C + 1)'(i_radius)) begin
                w_ok = 1'b0;
            end
            w_m[a] = m[RW-1:0];
        end
        w_d2 = (SQ + 2)'(r2_sq[0]) + (SQ + 2)'(r2_sq[1]) + (SQ + 2)'(r2_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ok <= w_ok;
        r2_ok <= r1_ok;
        for (int a = 0; a < 3; a++) begin
            r1_m[a]  <= w_m[a];
            r1_c[a]  <= i_pt[a*C +: C];
            r2_sq[a] <= r1_m[a] * r1_m[a];
            r2_c[a]  <= r1_c[a];
        end
        if (i_clear) begin
            r_cnt <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else if (r2_v && r2_ok && (w_d2 <= (SQ + 2)'(i_r2))) begin
            r_cnt <= r_cnt + 1'b1;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= r_sum[a] + SM'(r2_c[a]);
            end
        end
    end

    assign o_acc.busy  = i_valid | r1_v | r2_v;
    assign o_acc.sum_x = r_sum[0];
    assign o_acc.sum_y = r_sum[1];
    assign o_acc.sum_z = r_sum[2];
    assign o_acc.cnt   = r_cnt;
endmodule

// File: design/point_cloud_radius_smoothing_top.sv
// Top level of the point cloud radius smoothing block: controller and memories.
// Depends on pcrs_pkg, the channel interfaces, pcrs_ram, pcrs_nbr and pcrs_div.
//
// Input words carry a command: load stores one point, read-out returns the
// next smoothed point. A load word with in_last set starts smoothing (a pass
// count of zero marks the points smoothed at once); the configured number of
// passes then runs with the input not ready. Each pass visits every point i:
// it reads point i, sweeps all N points past it through the single read port
// of the source memory, lets the pipeline drain and runs the bit-serial
// divider. The two point memories swap roles after every pass. A read-out
// word yields one result word through the RAM read register and the output
// register; the next input word is accepted once that result has been taken.
// A read-out before smoothing yields nothing, and after the last point the
// read-out starts again at the first. Reset clears the point count and the
// ready-for-read-out flag and restores the register defaults; the memories
// are not cleared. A stalled receiver holds the result word and blocks input.
// Configuration writes are always ready; index 0 is the radius, 1 the pass count.
module point_cloud_radius_smoothing_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcrs_in_if.sink    i_in,
    pcrs_out_if.source o_res,
    pcrs_cfg_if.sink   i_cfg
);
    localparam int C  = pcrs_pkg::COORD_BITS;
    localparam int IW = pcrs_pkg::IDX_W;
    localparam int CW = pcrs_pkg::CNT_W;
    localparam int PW = pcrs_pkg::PT_W;
    localparam int SM = pcrs_pkg::SUM_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_RDSELF = 6'b000010,
        ST_WTSELF = 6'b000100,
        ST_SWEEP  = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_DIV    = 6'b100000
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_count;
    logic                            r_smoothed;
    logic [IW-1:0]                   r_rd, r_i, r_j, r_rtag;
    logic [pcrs_pkg::ITER_W-1:0]     r_pass, r_iter;
    logic [pcrs_pkg::RAD_W-1:0]      r_radius;
    logic [pcrs_pkg::SQ_W-1:0]       r_r2;
    logic                            r_sel, r_rv, r_pend, r_pend_last, r_clear;
    logic                            r_div_go, r_out_valid, r_out_last;
    logic [PW-1:0]                   r_self, r_out;

    logic                            w_in_acc, w_load, w_read, w_full;
    logic [IW-1:0]                   w_load_idx, w_raddr;
    logic [PW-1:0]                   w_rd0, w_rd1, w_src, w_load_pt;
    logic                            w_we0, w_we1;
    logic [IW-1:0]                   w_waddr0;
    logic [PW-1:0]                   w_wdata0;
    logic                            w_rd_last, w_i_last;
    pcrs_pkg::t_acc                  w_acc;
    pcrs_pkg::t_div_out              w_div;

    assign i_in.ready  = (r_state == ST_IDLE) && !r_pend && !r_out_valid;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_load      = w_in_acc && !i_in.command;
    assign w_read      = w_in_acc && i_in.command && r_smoothed && (r_count != '0);
    assign w_full      = !r_smoothed && (r_count == CW'(pcrs_pkg::MAX_POINTS));
    assign w_load_idx  = r_smoothed ? '0 : r_count[IW-1:0];
    assign w_load_pt   = {i_in.in_z, i_in.in_y, i_in.in_x};
    assign w_src       = r_sel ? w_rd1 : w_rd0;
    assign w_rd_last   = (CW'(r_rd) + 1'b1) == r_count;
    assign w_i_last    = (CW'(r_i) + 1'b1) == r_count;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        unique case (r_state)
            ST_RDSELF: w_raddr = r_i;
            ST_SWEEP:  w_raddr = r_j;
            default:   w_raddr = r_rd;
        endcase
    end

    assign w_we0    = (w_load && !w_full) || (w_div.done && r_sel);
    assign w_we1    = w_div.done && !r_sel;
    assign w_waddr0 = w_load ? w_load_idx : r_i;
    assign w_wdata0 = w_load ? w_load_pt : w_div.pt;

    pcrs_ram #(.W(PW), .D(pcrs_pkg::MAX_POINTS)) u_mem0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr0),
        .i_wdata (w_wdata0),
        .i_raddr (w_raddr),
        .o_rdata (w_rd0)
    );

    pcrs_ram #(.W(PW), .D(pcrs_pkg::MAX_POINTS)) u_mem1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (r_i),
        .i_wdata (w_div.pt),
        .i_raddr (w_raddr),
        .o_rdata (w_rd1)
    );

    pcrs_nbr u_nbr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (r_clear),
        .i_valid    (r_rv),
        .i_tag      (r_rtag),
        .i_self_idx (r_i),
        .i_self     (r_self),
        .i_pt       (w_src),
        .i_radius   (r_radius),
        .i_r2       (r_r2),
        .o_acc      (w_acc)
    );

    pcrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_sx    (w_acc.sum_x + SM'($signed(r_self[0 +: C]))),
        .i_sy    (w_acc.sum_y + SM'($signed(r_self[C +: C]))),
        .i_sz    (w_acc.sum_z + SM'($signed(r_self[2*C +: C]))),
        .i_den   (w_acc.cnt + 1'b1),
        .o_res   (w_div)
    );

    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
        if (r_state == ST_WTSELF) begin
            r_self <= w_src;
        end
        if (r_pend) begin
            r_out      <= w_src;
            r_out_last <= r_pend_last;
        end
        if (w_read) begin
            r_pend_last <= w_rd_last;
        end
        if (r_state == ST_SWEEP) begin
            r_rtag <= r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_smoothed  <= 1'b0;
            r_rd        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_pass      <= '0;
            r_sel       <= 1'b0;
            r_rv        <= 1'b0;
            r_pend      <= 1'b0;
            r_clear     <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_radius    <= pcrs_pkg::RAD_RESET;
            r_iter      <= pcrs_pkg::ITER_RESET;
        end else begin
            r_rv     <= (r_state == ST_SWEEP);
            r_clear  <= (r_state == ST_WTSELF);
            r_div_go <= (r_state == ST_DRAIN) && !w_acc.busy;
            r_pend   <= w_read;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    pcrs_pkg::CFG_RADIUS: r_radius <= i_cfg.data;
                    pcrs_pkg::CFG_ITER:   r_iter <= i_cfg.data[pcrs_pkg::ITER_W-1:0];
                    default:              r_radius <= r_radius;
                endcase
            end

            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_read) begin
                r_rd <= w_rd_last ? '0 : r_rd + 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_load) begin
                        r_smoothed <= i_in.in_last && (r_iter == '0);
                        if (!w_full) begin
                            r_count <= CW'(w_load_idx) + 1'b1;
                        end else if (r_smoothed) begin
                            r_count <= CW'(1);
                        end
                        if (i_in.in_last) begin
                            r_sel  <= 1'b0;
                            r_pass <= '0;
                            r_i    <= '0;
                            r_rd   <= '0;
                            if (r_iter != '0) begin
                                r_state <= ST_RDSELF;
                            end
                        end
                    end
                end
                ST_RDSELF: begin
                    r_state <= ST_WTSELF;
                end
                ST_WTSELF: begin
                    r_j     <= '0;
                    r_state <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    if ((CW'(r_j) + 1'b1) == r_count) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!w_acc.busy) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div.done) begin
                        if (w_i_last) begin
                            r_sel <= !r_sel;
                            r_i   <= '0;
                            if ((r_pass + 1'b1) == r_iter) begin
                                r_smoothed <= 1'b1;
                                r_rd       <= '0;
                                r_state    <= ST_IDLE;
                            end else begin
                                r_pass  <= r_pass + 1'b1;
                                r_state <= ST_RDSELF;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_RDSELF;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.out_x    = r_out[0 +: C];
    assign o_res.out_y    = r_out[C +: C];
    assign o_res.out_z    = r_out[2*C +: C];
    assign o_res.out_last = r_out_last;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == ST_IDLE))
        else $error("input ready outside the idle state");

    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_out_valid)
        else $error("read-out word did not reach the output register");

    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smoothed |-> (CW'(r_rd) < r_count))
        else $error("read-out index beyond the point count");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");
endmodule
